[rtl/core/decaying_harmonic_tone_synth_core_assert.svh]
// Assertion macros for the decaying harmonic tone synth core.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef DECAYING_HARMONIC_TONE_SYNTH_CORE_ASSERT_SVH
`define DECAYING_HARMONIC_TONE_SYNTH_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property at every clock edge outside reset
`define DHTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to an effect in the following cycle
`define DHTS_ASSERT_NEXT(lbl, cond, effect, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (effect)) \
        else $error(msg);

`else

`define DHTS_ASSERT(lbl, prop, msg)
`define DHTS_ASSERT_NEXT(lbl, cond, effect, msg)

`endif

`endif

[rtl/core/dhts_pkg.sv]
// Shared constants, types and helper functions of the decaying harmonic tone synth.
// No dependencies; used by every module of the core.
package dhts_pkg;

    // Configuration of the synthesizer
    localparam int SINE_TABLE_BITS  = 10;
    localparam int CYCLE_COUNT_BITS = 16;
    localparam int HARMONICS        = 6;

    // Sine table geometry
    localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;
    localparam int QUARTER_SIZE = 1 << QUARTER_BITS;
    localparam int SINE_W       = 16;
    localparam int SINE_MAG_W   = 15;

    // Datapath widths
    localparam int HCNT_W  = $clog2(HARMONICS) + 1;
    localparam int ACC_W   = SINE_W + HARMONICS;
    localparam int MAG_W   = ACC_W - 1;
    localparam int MX_LSB  = 14 + HARMONICS;
    localparam int FRAC_W  = 30;
    localparam int Q30_W   = 31;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Arithmetic constants
    localparam logic [CYCLE_COUNT_BITS-1:0] CYCLE_MAX = '1;
    localparam logic [MUL_B_W-1:0] DECAY_Q24   = 32'd60832;
    localparam logic [MUL_B_W-1:0] LN2_Q30     = 32'd744261118;
    localparam logic [Q30_W-1:0]   ONE_Q30     = 31'h4000_0000;
    localparam logic [2:0]         HORNER_TOP  = 3'd7;
    localparam logic [SINE_MAG_W-1:0] SAMPLE_PEAK = 15'd32767;
    localparam int RECIP_SHIFT = 33;

    // Reciprocals floor(2^33/k) for the Horner divisors that are not powers of two
    localparam logic [MUL_B_W-1:0] RECIP_3 = MUL_B_W'((64'd1 << RECIP_SHIFT) / 64'd3);
    localparam logic [MUL_B_W-1:0] RECIP_5 = MUL_B_W'((64'd1 << RECIP_SHIFT) / 64'd5);
    localparam logic [MUL_B_W-1:0] RECIP_6 = MUL_B_W'((64'd1 << RECIP_SHIFT) / 64'd6);
    localparam logic [MUL_B_W-1:0] RECIP_7 = MUL_B_W'((64'd1 << RECIP_SHIFT) / 64'd7);

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HARM,
        ST_HLAST,
        ST_ENV_Y,
        ST_ENV_YL,
        ST_HORN_MUL,
        ST_HORN_DIV,
        ST_HORN_FIX,
        ST_MAG,
        ST_SQ,
        ST_CUBE,
        ST_LOUD,
        ST_SCALE,
        ST_DONE
    } state_t;

    // Pick the reciprocal for a divisor that is not a power of two
    function automatic logic [MUL_B_W-1:0] horner_recip(input logic [2:0] k);
        case (k)
            3'd3:    return RECIP_3;
            3'd5:    return RECIP_5;
            3'd6:    return RECIP_6;
            3'd7:    return RECIP_7;
            default: return '0;
        endcase
    endfunction

endpackage

[rtl/core/dhts_sine_rom.sv]
// Sine lookup from a quarter-wave constant table, with registered read.
// Depends on dhts_pkg for table geometry.
module dhts_sine_rom (
    input  logic                                     clk,
    input  logic [dhts_pkg::SINE_TABLE_BITS-1:0]     idx,
    output logic signed [dhts_pkg::SINE_W-1:0]       data
);

    typedef logic [dhts_pkg::QUARTER_SIZE-1:0][dhts_pkg::SINE_MAG_W-1:0] quarter_table_t;

    // Odd polynomial for sin over a quarter cycle, scaled to Q1.15
    function automatic logic [dhts_pkg::SINE_MAG_W-1:0] quarter_sine(input int unsigned j);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] v;
        z  = 64'(j) << (30 - dhts_pkg::QUARTER_BITS);
        z2 = (z * z) >> 30;
        p  = 64'd172272;
        p  = 64'd5026995 - ((z2 * p) >> 30);
        p  = 64'd85569309 - ((z2 * p) >> 30);
        p  = 64'd693598670 - ((z2 * p) >> 30);
        p  = 64'd1686629713 - ((z2 * p) >> 30);
        v  = (z * p) >> 30;
        v  = (v * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[dhts_pkg::SINE_MAG_W-1:0];
    endfunction

    function automatic quarter_table_t build_table();
        quarter_table_t tbl;
        int unsigned    i;
        for (i = 0; i < dhts_pkg::QUARTER_SIZE; i++) begin
            tbl[i] = quarter_sine(i);
        end
        return tbl;
    endfunction

    localparam quarter_table_t QTABLE = build_table();
    localparam logic [dhts_pkg::SINE_MAG_W-1:0] QPEAK = quarter_sine(dhts_pkg::QUARTER_SIZE);

    logic [1:0]                             quad;
    logic [dhts_pkg::QUARTER_BITS-1:0]      j;
    logic [dhts_pkg::QUARTER_BITS:0]        addr;
    logic [dhts_pkg::SINE_MAG_W-1:0]        mag;
    logic signed [dhts_pkg::SINE_W-1:0]     value;
    logic signed [dhts_pkg::SINE_W-1:0]     data_reg;

    // Mirror the index in odd quadrants, negate in the second half cycle
    assign quad  = idx[dhts_pkg::SINE_TABLE_BITS-1 -: 2];
    assign j     = idx[dhts_pkg::QUARTER_BITS-1:0];
    assign addr  = quad[0] ? ((dhts_pkg::QUARTER_BITS+1)'(dhts_pkg::QUARTER_SIZE) - {1'b0, j})
                           : {1'b0, j};
    assign mag   = addr[dhts_pkg::QUARTER_BITS] ? QPEAK
                                                : QTABLE[addr[dhts_pkg::QUARTER_BITS-1:0]];
    assign value = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    // Register the read
    always_ff @(posedge clk)
    begin
        data_reg <= value;
    end

    assign data = data_reg;

endmodule

[rtl/core/dhts_mul.sv]
// Shared unsigned multiplier with registered product.
// Depends on dhts_pkg for operand widths.
module dhts_mul (
    input  logic                          clk,
    input  logic                          en,
    input  logic [dhts_pkg::MUL_A_W-1:0]  a,
    input  logic [dhts_pkg::MUL_B_W-1:0]  b,
    output logic [dhts_pkg::PROD_W-1:0]   prod
);

    logic [dhts_pkg::PROD_W-1:0] prod_reg;

    // Capture the product when an operation is issued
    always_ff @(posedge clk)
    begin
        if (en) begin
            prod_reg <= dhts_pkg::PROD_W'(a) * dhts_pkg::PROD_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

[rtl/core/decaying_harmonic_tone_synth_core.sv]
// Top level of the decaying harmonic tone synth: handshake, phase state, sequencer.
// Depends on dhts_pkg, dhts_sine_rom, dhts_mul and the assertion header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one sample tick of a note:
//   note_start, phase_step (Q0.32 cycles per sample) and loudness (Q1.16).
//   Output channel (out_valid/out_ready) returns one signed sample per beat.
//   Each beat runs through a sequencer around one shared multiplier: six
//   sine lookups, a 7-term Horner exponential for the decay envelope (one or
//   two multiplies per term), then x + x^3 shaping, loudness and clamping.
//   in_ready is high only while the sequencer is idle, so no new beat is
//   taken until the last one leaves it; the multiplier sets the pace.
//   A finished sample waits in the output register; a new beat is accepted
//   while it waits, and the next result holds until the receiver takes it.
//   Reset clears the phase, the whole cycle count and the output valid.
//   The phase advances and the cycle count updates at the accept edge.
`include "decaying_harmonic_tone_synth_core_assert.svh"

module decaying_harmonic_tone_synth_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  note_start,
    input  logic [31:0]                           phase_step,
    input  logic [16:0]                           loudness,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [15:0]                    sample
);

    localparam int STB = dhts_pkg::SINE_TABLE_BITS;
    localparam int CCB = dhts_pkg::CYCLE_COUNT_BITS;

    // Control registers
    dhts_pkg::state_t state_reg, state_next;
    logic [31:0]                    phase_fraction_reg, phase_fraction_next;
    logic [CCB-1:0]                 cycle_count_reg, cycle_count_next;
    logic [dhts_pkg::HCNT_W-1:0]    h_cnt_reg, h_cnt_next;
    logic                           rom_vld_reg, rom_vld_next;
    logic [2:0]                     k_reg, k_next;
    logic                           out_valid_reg, out_valid_next;

    // Payload registers
    logic [31:0]                        base_reg, base_next;
    logic [31:0]                        ph_reg, ph_next;
    logic [CCB-1:0]                     cc_work_reg, cc_work_next;
    logic [16:0]                        loud_reg, loud_next;
    logic signed [dhts_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [dhts_pkg::FRAC_W-1:0]        y_reg, y_next;
    logic [dhts_pkg::Q30_W-1:0]         t_reg, t_next;
    logic [dhts_pkg::FRAC_W-1:0]        p_reg, p_next;
    logic [4:0]                         sh_reg, sh_next;
    logic                               env_zero_reg, env_zero_next;
    logic [dhts_pkg::Q30_W-1:0]         env_reg, env_next;
    logic [30:0]                        mx_reg, mx_next;
    logic signed [15:0]                 res_reg, res_next;
    logic signed [15:0]                 sample_reg, sample_next;

    // Shared units
    logic [STB-1:0]                     rom_idx;
    logic signed [dhts_pkg::SINE_W-1:0] rom_data;
    logic                               mul_en;
    logic [dhts_pkg::MUL_A_W-1:0]       mul_a;
    logic [dhts_pkg::MUL_B_W-1:0]       mul_b;
    logic [dhts_pkg::PROD_W-1:0]        prod;

    // Datapath helpers
    logic                               in_accept;
    logic [31:0]                        pf_eff;
    logic [CCB-1:0]                     cc_eff;
    logic [32:0]                        phase_sum;
    logic                               acc_neg;
    logic [dhts_pkg::ACC_W-1:0]         acc_abs;
    logic [dhts_pkg::MAG_W-1:0]         mag;
    logic                               e_far;
    logic [dhts_pkg::FRAC_W-1:0]        horner_p;
    logic                               k_pow2;
    logic [1:0]                         k_shift;
    logic [dhts_pkg::FRAC_W-1:0]        q_pow2;
    logic [dhts_pkg::FRAC_W-1:0]        q0;
    logic [32:0]                        q0k;
    logic [32:0]                        rem;
    logic [dhts_pkg::FRAC_W-1:0]        q_fix;
    logic [dhts_pkg::Q30_W-1:0]         t_pow2;
    logic [dhts_pkg::Q30_W-1:0]         t_fix;
    logic [dhts_pkg::Q30_W-1:0]         env_val;
    logic [30:0]                        mx;
    logic [31:0]                        sq;
    logic [32:0]                        cube;
    logic [33:0]                        shaped;
    logic [50:0]                        w;
    logic [60:0]                        w_scaled;
    logic [dhts_pkg::SINE_MAG_W-1:0]    s;
    logic signed [15:0]                 res_val;

    dhts_sine_rom u_rom (
        .clk  (clk),
        .idx  (rom_idx),
        .data (rom_data)
    );

    dhts_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Handshake
    assign in_ready  = (state_reg == dhts_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // Phase state as seen by this beat, and its advance
    assign pf_eff    = note_start ? '0 : phase_fraction_reg;
    assign cc_eff    = note_start ? '0 : cycle_count_reg;
    assign phase_sum = {1'b0, pf_eff} + {1'b0, phase_step};

    // Sine lookup address: top bits of the harmonic phase
    assign rom_idx = ph_reg[31 -: STB];

    // Sign and magnitude of the harmonic sum
    assign acc_neg = acc_reg[dhts_pkg::ACC_W-1];
    assign acc_abs = acc_neg ? -acc_reg : acc_reg;
    assign mag     = acc_abs[dhts_pkg::MAG_W-1:0];

    // Envelope exponent: whole part selects the shift, far decay gives zero
    assign e_far = (prod[47:24] > 24'd30);

    // Horner step: divide by k, by shift or by reciprocal with one correction
    assign horner_p = prod[59:30];
    assign k_pow2   = k_reg inside {3'd1, 3'd2, 3'd4};
    always_comb
    begin
        case (k_reg)
            3'd4:    k_shift = 2'd2;
            3'd2:    k_shift = 2'd1;
            default: k_shift = 2'd0;
        endcase
    end
    assign q_pow2  = horner_p >> k_shift;
    assign q0      = prod[dhts_pkg::RECIP_SHIFT+29:dhts_pkg::RECIP_SHIFT];
    assign q0k     = 33'(q0) * 33'(k_reg);
    assign rem     = 33'(p_reg) - q0k;
    assign q_fix   = (rem >= 33'(k_reg)) ? (q0 + 30'd1) : q0;
    assign t_pow2  = dhts_pkg::ONE_Q30 - dhts_pkg::Q30_W'(q_pow2);
    assign t_fix   = dhts_pkg::ONE_Q30 - dhts_pkg::Q30_W'(q_fix);
    assign env_val = env_zero_reg ? '0 : (t_pow2 >> sh_reg);

    // Shaping x + x^3 and final scaling
    assign mx       = prod[dhts_pkg::MX_LSB+30:dhts_pkg::MX_LSB];
    assign sq       = prod[61:30];
    assign cube     = prod[62:30];
    assign shaped   = 34'(mx_reg) + 34'(cube);
    assign w        = prod[50:0];
    assign w_scaled = {w[45:0], 15'd0} - 61'(w[45:0]);
    assign s        = (|w[50:46]) ? dhts_pkg::SAMPLE_PEAK : w_scaled[60:46];
    assign res_val  = acc_neg ? -$signed({1'b0, s}) : $signed({1'b0, s});

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next          = state_reg;
        phase_fraction_next = phase_fraction_reg;
        cycle_count_next    = cycle_count_reg;
        h_cnt_next          = h_cnt_reg;
        rom_vld_next        = (state_reg == dhts_pkg::ST_HARM);
        k_next              = k_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        base_next           = base_reg;
        ph_next             = ph_reg;
        cc_work_next        = cc_work_reg;
        loud_next           = loud_reg;
        acc_next            = acc_reg;
        y_next              = y_reg;
        t_next              = t_reg;
        p_next              = p_reg;
        sh_next             = sh_reg;
        env_zero_next       = env_zero_reg;
        env_next            = env_reg;
        mx_next             = mx_reg;
        res_next            = res_reg;
        sample_next         = sample_reg;
        mul_en              = 1'b0;
        mul_a               = '0;
        mul_b               = '0;

        // Fold in the previous lookup, highest weight first
        if (rom_vld_reg) begin
            acc_next = (acc_reg <<< 1) + dhts_pkg::ACC_W'(rom_data);
        end

        case (state_reg)
            dhts_pkg::ST_IDLE:
            begin
                if (in_accept) begin
                    base_next           = pf_eff;
                    ph_next             = pf_eff;
                    cc_work_next        = cc_eff;
                    loud_next           = loudness;
                    acc_next            = '0;
                    h_cnt_next          = dhts_pkg::HCNT_W'(1);
                    phase_fraction_next = phase_sum[31:0];
                    if (phase_sum[32] && (cc_eff != dhts_pkg::CYCLE_MAX)) begin
                        cycle_count_next = cc_eff + 1'b1;
                    end else begin
                        cycle_count_next = cc_eff;
                    end
                    state_next = dhts_pkg::ST_HARM;
                end
            end
            dhts_pkg::ST_HARM:
            begin
                ph_next    = ph_reg + base_reg;
                h_cnt_next = h_cnt_reg + 1'b1;
                if (h_cnt_reg == dhts_pkg::HCNT_W'(dhts_pkg::HARMONICS)) begin
                    state_next = dhts_pkg::ST_HLAST;
                end
            end
            dhts_pkg::ST_HLAST:
            begin
                // Issue cycles * decay rate
                mul_en     = 1'b1;
                mul_a      = dhts_pkg::MUL_A_W'(cc_work_reg);
                mul_b      = dhts_pkg::DECAY_Q24;
                state_next = dhts_pkg::ST_ENV_Y;
            end
            dhts_pkg::ST_ENV_Y:
            begin
                // Split the exponent, issue fraction * ln2
                env_zero_next = e_far;
                sh_next       = prod[28:24];
                mul_en        = 1'b1;
                mul_a         = dhts_pkg::MUL_A_W'({prod[23:0], 6'd0});
                mul_b         = dhts_pkg::LN2_Q30;
                state_next    = dhts_pkg::ST_ENV_YL;
            end
            dhts_pkg::ST_ENV_YL:
            begin
                y_next     = prod[59:30];
                t_next     = dhts_pkg::ONE_Q30;
                k_next     = dhts_pkg::HORNER_TOP;
                state_next = dhts_pkg::ST_HORN_MUL;
            end
            dhts_pkg::ST_HORN_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = dhts_pkg::MUL_A_W'(y_reg);
                mul_b      = dhts_pkg::MUL_B_W'(t_reg);
                state_next = dhts_pkg::ST_HORN_DIV;
            end
            dhts_pkg::ST_HORN_DIV:
            begin
                p_next = horner_p;
                if (k_pow2) begin
                    t_next = t_pow2;
                    k_next = k_reg - 1'b1;
                    if (k_reg == 3'd1) begin
                        env_next   = env_val;
                        state_next = dhts_pkg::ST_MAG;
                    end else begin
                        state_next = dhts_pkg::ST_HORN_MUL;
                    end
                end else begin
                    mul_en     = 1'b1;
                    mul_a      = dhts_pkg::MUL_A_W'(horner_p);
                    mul_b      = dhts_pkg::horner_recip(k_reg);
                    state_next = dhts_pkg::ST_HORN_FIX;
                end
            end
            dhts_pkg::ST_HORN_FIX:
            begin
                t_next     = t_fix;
                k_next     = k_reg - 1'b1;
                state_next = dhts_pkg::ST_HORN_MUL;
            end
            dhts_pkg::ST_MAG:
            begin
                mul_en     = 1'b1;
                mul_a      = dhts_pkg::MUL_A_W'(mag);
                mul_b      = dhts_pkg::MUL_B_W'(env_reg);
                state_next = dhts_pkg::ST_SQ;
            end
            dhts_pkg::ST_SQ:
            begin
                mx_next    = mx;
                mul_en     = 1'b1;
                mul_a      = dhts_pkg::MUL_A_W'(mx);
                mul_b      = dhts_pkg::MUL_B_W'(mx);
                state_next = dhts_pkg::ST_CUBE;
            end
            dhts_pkg::ST_CUBE:
            begin
                mul_en     = 1'b1;
                mul_a      = dhts_pkg::MUL_A_W'(sq);
                mul_b      = dhts_pkg::MUL_B_W'(mx_reg);
                state_next = dhts_pkg::ST_LOUD;
            end
            dhts_pkg::ST_LOUD:
            begin
                mul_en     = 1'b1;
                mul_a      = shaped;
                mul_b      = dhts_pkg::MUL_B_W'(loud_reg);
                state_next = dhts_pkg::ST_SCALE;
            end
            dhts_pkg::ST_SCALE:
            begin
                res_next   = res_val;
                state_next = dhts_pkg::ST_DONE;
            end
            dhts_pkg::ST_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready) begin
                    sample_next    = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = dhts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dhts_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg          <= dhts_pkg::ST_IDLE;
            phase_fraction_reg <= '0;
            cycle_count_reg    <= '0;
            h_cnt_reg          <= '0;
            rom_vld_reg        <= 1'b0;
            k_reg              <= '0;
            out_valid_reg      <= 1'b0;
        end else begin
            state_reg          <= state_next;
            phase_fraction_reg <= phase_fraction_next;
            cycle_count_reg    <= cycle_count_next;
            h_cnt_reg          <= h_cnt_next;
            rom_vld_reg        <= rom_vld_next;
            k_reg              <= k_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        ph_reg       <= ph_next;
        cc_work_reg  <= cc_work_next;
        loud_reg     <= loud_next;
        acc_reg      <= acc_next;
        y_reg        <= y_next;
        t_reg        <= t_next;
        p_reg        <= p_next;
        sh_reg       <= sh_next;
        env_zero_reg <= env_zero_next;
        env_reg      <= env_next;
        mx_reg       <= mx_next;
        res_reg      <= res_next;
        sample_reg   <= sample_next;
    end

    // Drop ready for the whole computation after a beat is taken
    `DHTS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high")

    // Advance the phase by the step of the accepted beat
    `DHTS_ASSERT_NEXT(a_phase_advance, in_valid && in_ready && !note_start,
        phase_fraction_reg == $past(phase_fraction_reg) + $past(phase_step),
        "phase advance wrong")

    // Restart the phase from zero at a note start
    `DHTS_ASSERT_NEXT(a_note_restart, in_valid && in_ready && note_start,
        phase_fraction_reg == $past(phase_step), "note start phase wrong")

    // Never lower the cycle count within a note
    `DHTS_ASSERT_NEXT(a_cycles_monotonic, in_valid && in_ready && !note_start,
        cycle_count_reg >= $past(cycle_count_reg), "cycle count dropped")

    // Keep the output inside the symmetric clamp range
    `DHTS_ASSERT(a_sample_clamped, !out_valid || (sample != 16'sh8000), "sample outside clamp")

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for decaying_harmonic_tone_synth_core.
// Depends on dhts_pkg and the core RTL; predicts every sample with its own
// integer tone model and checks beats under random idling and back-pressure.
`timescale 1ns / 100ps

module testbench;

    localparam int TAB_BITS   = dhts_pkg::SINE_TABLE_BITS;
    localparam int TAB_SIZE   = 1 << TAB_BITS;
    localparam int NUM_HARM   = dhts_pkg::HARMONICS;
    localparam int CYC_LIMIT  = (1 << dhts_pkg::CYCLE_COUNT_BITS) - 1;
    localparam int MAX_REPORT = 10;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_TICKS = 1400;
    localparam int LONG_NOTE_TICKS = 200;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               note_start;
    logic [31:0]        phase_step;
    logic [16:0]        loudness;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] sample;

    // Tone model state
    bit signed [15:0] sine_tab [TAB_SIZE];
    bit [31:0]        tone_phase;
    bit [31:0]        tone_cycles;
    bit [15:0]        expected_samples[$];

    // Run bookkeeping
    bit idle_on;
    int rx_hold_left;
    int fail_count;
    int report_count;
    int ticks_sent;
    int samples_checked;
    int notes_started;
    int peak_cycles;

    decaying_harmonic_tone_synth_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .note_start (note_start),
        .phase_step (phase_step),
        .loudness   (loudness),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample     (sample)
    );

    // Toggle the clock every half period
    always
    begin
        #1 clk = ~clk;
    end

    // One quarter-wave point of the sine table, Q1.15 magnitude
    function automatic bit [63:0] quarter_point(input int unsigned j);
        bit [63:0] z;
        bit [63:0] z2;
        bit [63:0] p;
        bit [63:0] v;
        z  = 64'(j) << (30 - (TAB_BITS - 2));
        z2 = (z * z) >> 30;
        p  = 64'd172272;
        p  = 64'd5026995 - ((z2 * p) >> 30);
        p  = 64'd85569309 - ((z2 * p) >> 30);
        p  = 64'd693598670 - ((z2 * p) >> 30);
        p  = 64'd1686629713 - ((z2 * p) >> 30);
        v  = (z * p) >> 30;
        v  = (v * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
            v = 64'd32767;
        return v;
    endfunction

    // Fill the full-cycle table from quarter-wave symmetry
    function automatic void build_sine_table();
        int unsigned q;
        int unsigned quad;
        int unsigned j;
        bit [63:0]   v;
        q = 1 << (TAB_BITS - 2);
        for (int unsigned i = 0; i < TAB_SIZE; i++)
        begin
            quad = (i >> (TAB_BITS - 2)) & 3;
            j    = i & (q - 1);
            v    = (quad & 1) ? quarter_point(q - j) : quarter_point(j);
            sine_tab[i] = (quad & 2) ? -16'(v) : 16'(v);
        end
    endfunction

    // Decay envelope in Q30 for a whole-cycle count
    function automatic bit [63:0] decay_envelope(input bit [31:0] cycles);
        bit [63:0] e;
        bit [63:0] n;
        bit [63:0] f;
        bit [63:0] y;
        bit [63:0] t;
        e = 64'(cycles) * 64'd60832;
        n = e >> 24;
        f = e & 64'hFF_FFFF;
        y = ((f << 6) * 64'd744261118) >> 30;
        t = 64'd1 << 30;
        for (int k = 7; k >= 1; k--)
            t = (64'd1 << 30) - (((y * t) >> 30) / 64'(k));
        if (n > 30)
            return 64'd0;
        return t >> n;
    endfunction

    // Form the sample of one tick, then advance phase and cycle count
    function automatic bit [15:0] predict_sample(input bit start, input bit [31:0] stp,
                                                 input bit [16:0] loud);
        longint    acc;
        bit [63:0] prod;
        bit [31:0] ph;
        bit [31:0] next_phase;
        bit [63:0] mag;
        bit [63:0] mx;
        bit [63:0] cube;
        bit [63:0] w;
        bit [63:0] s;
        bit [15:0] result;
        if (start)
        begin
            tone_phase  = '0;
            tone_cycles = '0;
        end
        acc = 0;
        for (int h = 1; h <= NUM_HARM; h++)
        begin
            prod = 64'(h) * 64'(tone_phase);
            ph   = prod[31:0];
            acc += longint'(sine_tab[ph >> (32 - TAB_BITS)]) * (longint'(1) << (NUM_HARM - h));
        end
        mag  = (acc < 0) ? 64'(-acc) : 64'(acc);
        mx   = (mag * decay_envelope(tone_cycles)) >> (14 + NUM_HARM);
        cube = (((mx * mx) >> 30) * mx) >> 30;
        w    = (mx + cube) * 64'(loud);
        if (w >= (64'd1 << 46))
            s = 64'd32767;
        else
            s = (w * 64'd32767) >> 46;
        result = (acc < 0) ? -16'(s) : 16'(s);
        next_phase = tone_phase + stp;
        if (next_phase < tone_phase && tone_cycles < CYC_LIMIT)
            tone_cycles++;
        tone_phase = next_phase;
        if (int'(tone_cycles) > peak_cycles)
            peak_cycles = tone_cycles;
        return result;
    endfunction

    // Offer one tick and hold it until the core takes the beat
    task automatic send_tick(input bit start, input bit [31:0] stp, input bit [16:0] loud);
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(99) < 18)
        begin
            gap = $urandom_range(40, 1);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        note_start <= start;
        phase_step <= stp;
        loudness   <= loud;
        do
            @(posedge clk);
        while (!in_ready);
        expected_samples.push_back(predict_sample(start, stp, loud));
        ticks_sent++;
        if (start)
            notes_started++;
    endtask

    // Receiver side: long hold-off on request, random stalls while idling is on, always ready otherwise
    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left--;
        end
        else if (idle_on)
            out_ready <= ($urandom_range(99) >= 18);
        else
            out_ready <= 1'b1;
    end

    // Compare each output beat with the oldest predicted sample
    always @(posedge clk)
    begin : check_beat
        bit [15:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                fail_count++;
                if (report_count < MAX_REPORT)
                    $display("%0t: unexpected sample %0d with nothing pending", $realtime,
                             sample);
                report_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (sample !== want)
                begin
                    fail_count++;
                    if (report_count < MAX_REPORT)
                        $display("%0t: sample %0d expected %0d, got %0d", $realtime,
                                 samples_checked, $signed(want), sample);
                    report_count++;
                end
                samples_checked++;
            end
        end
    end

    // Fields at their extremes, zero step, start behavior, loudness above one
    task automatic test_directed_edges();
        send_tick(1'b0, 32'h4000_0000, 17'd65536);
        send_tick(1'b0, 32'h4000_0000, 17'd65536);
        send_tick(1'b0, 32'h1234_5678, 17'd65536);
        send_tick(1'b1, 32'hFFFF_FFFF, 17'd131071);
        send_tick(1'b0, 32'hFFFF_FFFF, 17'd131071);
        send_tick(1'b0, 32'hFFFF_FFFF, 17'd65537);
        send_tick(1'b0, 32'h0000_0000, 17'd65536);
        send_tick(1'b0, 32'h0000_0000, 17'd65536);
        send_tick(1'b0, 32'h0000_0000, 17'd0);
        send_tick(1'b1, 32'h0000_0000, 17'd65536);
        send_tick(1'b0, 32'h0000_0000, 17'd65536);
        send_tick(1'b1, 32'h0100_0000, 17'd65536);
        send_tick(1'b0, 32'h0100_0000, 17'd65536);
        send_tick(1'b0, 32'h0100_0000, 17'd1);
        send_tick(1'b0, 32'h0100_0000, 17'd32768);
        send_tick(1'b1, 32'h8000_0000, 17'd65536);
        send_tick(1'b0, 32'h8000_0000, 17'd65536);
        send_tick(1'b0, 32'h2AAA_AAAB, 17'd131071);
        send_tick(1'b0, 32'h0000_0001, 17'd65536);
        send_tick(1'b0, 32'h5555_5555, 17'd98304);
    endtask

    // Notes of random length and pitch, with some broken or noisy runs
    task automatic test_random_notes(input int n_ticks);
        int        sent;
        int        kind;
        int        run_len;
        bit        jitter;
        bit        lead;
        bit [31:0] stp;
        bit [16:0] loud;
        sent = 0;
        while (sent < n_ticks)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
                stp = $urandom_range(32'd500000000, 32'd1950000);
            else if (kind < 70)
                stp = $urandom;
            else if (kind < 80)
                stp = 32'd0;
            else
                stp = 32'h8000_0000 | $urandom;
            if ($urandom_range(99) < 15)
                loud = 17'($urandom_range(131071, 65537));
            else
                loud = 17'($urandom_range(65536, 0));
            jitter  = ($urandom_range(99) < 8);
            lead    = ($urandom_range(99) < 90);
            run_len = $urandom_range(80, 1);
            for (int k = 0; k < run_len && sent < n_ticks; k++)
            begin
                if (jitter)
                    stp = $urandom;
                send_tick((k == 0) ? lead : ($urandom_range(199) == 0), stp, loud);
                sent++;
            end
        end
    endtask

    // Stall the receiver long enough that the input side backs up
    task automatic test_output_hold_off();
        rx_hold_left = HOLD_OFF_CYCLES;
        send_tick(1'b1, 32'h0200_0000, 17'd65536);
        for (int k = 0; k < 14; k++)
            send_tick(1'b0, $urandom, 17'($urandom_range(65536, 0)));
    endtask

    // Run one long note with no idling so the cycle count climbs every tick
    task automatic test_long_note();
        idle_on = 1'b0;
        send_tick(1'b1, 32'hFFFF_FFFF, 17'd65536);
        for (int k = 0; k < LONG_NOTE_TICKS; k++)
            send_tick(1'b0, {16'hFFFF, 16'($urandom)}, 17'($urandom_range(131071, 32768)));
        idle_on = 1'b1;
    endtask

    // Bound the run in case the core stops answering
    initial
    begin
        #30_000_000;
        $display("decaying_harmonic_tone_synth_core: mismatch");
        $finish;
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        note_start   = 1'b0;
        phase_step   = '0;
        loudness     = '0;
        out_ready    = 1'b0;
        idle_on      = 1'b1;
        rx_hold_left = 0;
        tone_phase   = '0;
        tone_cycles  = '0;
        build_sine_table();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_edges();
        test_output_hold_off();
        test_random_notes(RANDOM_TICKS);
        test_long_note();
        test_random_notes(200);

        // Drop valid and drain the pending samples
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_count += expected_samples.size();

        $display("Sent %0d ticks over %0d note starts; %0d samples checked, %0d failures.",
                 ticks_sent, notes_started, samples_checked, fail_count);
        $display("Peak cycle count %0d (saturation at %0d); one %0d-cycle output hold-off.",
                 peak_cycles, CYC_LIMIT, HOLD_OFF_CYCLES);
        if (fail_count == 0)
            $display("decaying_harmonic_tone_synth_core: match");
        else
            $display("decaying_harmonic_tone_synth_core: mismatch");
        $finish;
    end

endmodule
